>>> rtl/core/skf_pkg.sv
// Shared types and constants for the scalar Kalman filter.
package skf_pkg;

    localparam int DATA_W = 32;
    localparam int GAIN_W = 17;
    localparam int VAR_W  = 31;
    localparam int IDX_W  = 2;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_TRANSITION = 2'd0;
    localparam logic [IDX_W-1:0] REG_CONTROL    = 2'd1;
    localparam logic [IDX_W-1:0] REG_PROC_NOISE = 2'd2;
    localparam logic [IDX_W-1:0] REG_MEAS_NOISE = 2'd3;

    localparam logic [VAR_W-1:0] PROC_NOISE_RST = 31'd655;

    typedef struct packed {
        logic signed [DATA_W-1:0] measured_value;
        logic signed [DATA_W-1:0] control_input;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] estimate;
        logic [GAIN_W-1:0]        gain;
        logic [VAR_W-1:0]         variance;
    } t_out_item;

    // sequencing of one serial multiplier
    typedef struct packed {
        logic load;
        logic step;
        logic last;
    } t_mul_ctrl;

endpackage

>>> rtl/core/skf_ser_mul.sv
// Shift-add multiplier that consumes one multiplier bit per cycle while step is asserted.
module skf_ser_mul #(
    parameter int MW     = 32,
    parameter int LW     = 32,
    parameter bit SIGNED = 1'b1
) (
    input  logic                     i_clk,
    input  skf_pkg::t_mul_ctrl       i_ctrl,
    input  logic signed [MW-1:0]     i_mcand,
    input  logic [LW-1:0]            i_mplier,
    output logic signed [MW+LW+1:0]  o_prod
);

    localparam int HW = MW + 2;

    logic signed [HW-1:0] r_hi;
    logic [LW-1:0]        r_lo;
    logic signed [HW-1:0] mc_ext;
    logic signed [HW-1:0] addend;
    logic signed [HW-1:0] sum;

    assign mc_ext = HW'(i_mcand);

    // the sign bit of a two's complement multiplier carries negative weight
    always_comb begin
        if (!r_lo[0]) begin
            addend = '0;
        end else if (SIGNED && i_ctrl.last) begin
            addend = -mc_ext;
        end else begin
            addend = mc_ext;
        end
    end

    assign sum = r_hi + addend;

    // low product bits shift in where the multiplier bits shift out
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_hi <= '0;
            r_lo <= i_mplier;
        end else if (i_ctrl.step) begin
            r_hi <= sum >>> 1;
            r_lo <= {sum[0], r_lo[LW-1:1]};
        end
    end

    assign o_prod = {r_hi, r_lo};

endmodule

>>> rtl/core/skf_div.sv
// Restoring divider that yields one quotient bit per cycle for the gain.
module skf_div #(
    parameter int QW = 17
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [skf_pkg::VAR_W-1:0]  i_num,
    input  logic [skf_pkg::VAR_W:0]    i_den,
    output logic                       o_busy,
    output logic [QW-1:0]              o_quot
);

    localparam int CW = $clog2(QW);

    logic [skf_pkg::VAR_W+1:0] r_rem;
    logic [skf_pkg::VAR_W:0]   r_den;
    logic [QW-1:0]             r_quot;
    logic [CW-1:0]             r_cnt;
    logic                      r_busy;

    logic [skf_pkg::VAR_W+2:0] trial;
    logic                      ge;
    logic [skf_pkg::VAR_W+1:0] after;

    assign trial = {1'b0, r_rem} - {2'b00, r_den};
    assign ge    = !trial[skf_pkg::VAR_W+2];
    assign after = ge ? trial[skf_pkg::VAR_W+1:0] : r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CW'(QW - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // remainder stays below the divisor, so the doubled value fits
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {2'b00, i_num};
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem  <= {after[skf_pkg::VAR_W:0], 1'b0};
            r_quot <= {r_quot[QW-2:0], ge};
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;

endmodule

>>> rtl/core/scalar_kalman_filter.sv
// Scalar Kalman filter top level: sequencer, state, configuration and output register.
// A request passes through the states PREP, PRED, SUM, CORR and DONE. PREP checks the
// denominator and starts the divider on the predicted variance. In PRED two
// bit-serial multipliers form a*x and b*u while the serial divider produces the gain
// one bit per cycle. SUM saturates the prediction. In CORR two more serial
// multipliers apply the gain to the innovation and to the variance, and DONE loads
// the output register once it is empty or being taken. A new request is taken
// once the previous result sits in the output register, even while that result
// is still stalled.
module scalar_kalman_filter #(
    parameter int FRAC_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  skf_pkg::t_in_item             i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output skf_pkg::t_out_item            o_out_data,
    input  logic                          i_cfg_we,
    input  logic [skf_pkg::IDX_W-1:0]     i_cfg_index,
    input  logic [skf_pkg::DATA_W-1:0]    i_cfg_data
);

    localparam int KW = FRAC_BITS + 1;
    localparam logic [KW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    localparam int PW = 2 * skf_pkg::DATA_W + 2;   // one prediction product
    localparam int CPW = skf_pkg::DATA_W + 3 + KW; // correction product
    localparam int VPW = skf_pkg::DATA_W + 2 + KW; // variance product

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PREP = 3'd1;
    localparam logic [2:0] S_PRED = 3'd2;
    localparam logic [2:0] S_SUM  = 3'd3;
    localparam logic [2:0] S_CORR = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    localparam logic [4:0] PRED_LAST = 5'd31;
    localparam logic [4:0] CORR_LAST = 5'(FRAC_BITS);

    logic [2:0] r_state;
    logic [4:0] r_cnt;

    logic signed [skf_pkg::DATA_W-1:0] r_a;
    logic signed [skf_pkg::DATA_W-1:0] r_b;
    logic [skf_pkg::VAR_W-1:0]         r_qn;
    logic [skf_pkg::VAR_W-1:0]         r_rn;

    logic signed [skf_pkg::DATA_W-1:0] r_est;
    logic [skf_pkg::VAR_W-1:0]         r_var;

    logic signed [skf_pkg::DATA_W-1:0] r_z;
    logic [skf_pkg::VAR_W-1:0]         r_pv;
    logic                              r_den_zero;
    logic signed [skf_pkg::DATA_W-1:0] r_pred;
    logic [KW-1:0]                     r_k;

    skf_pkg::t_out_item r_out;
    logic               r_out_valid;

    logic in_fire;
    logic done_fire;

    // predicted variance, saturated to 31 bits
    logic [skf_pkg::VAR_W:0] pv_sum;
    logic [skf_pkg::VAR_W-1:0] pv_sat;
    logic [skf_pkg::VAR_W:0] den;

    skf_pkg::t_mul_ctrl pred_ctrl;
    skf_pkg::t_mul_ctrl corr_ctrl;

    logic signed [PW-1:0]  prod_ax;
    logic signed [PW-1:0]  prod_bu;
    logic signed [CPW-1:0] prod_c;
    logic [VPW-1:0]        prod_v;

    logic signed [PW:0]    pred_sum;
    logic signed [PW:0]    pred_sh;
    logic signed [skf_pkg::DATA_W-1:0] pred_sat;

    logic                  div_busy;
    logic [KW-1:0]         div_quot;
    logic [KW-1:0]         kval;

    logic signed [skf_pkg::DATA_W:0]   innov;
    logic signed [skf_pkg::DATA_W+3:0] corr;
    logic signed [skf_pkg::DATA_W+4:0] est_sum;
    logic signed [skf_pkg::DATA_W-1:0] est_sat;
    logic [skf_pkg::VAR_W-1:0]         newp;

    assign in_fire   = i_in_valid && !o_in_stall;
    assign done_fire = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    assign pv_sum = {1'b0, r_var} + {1'b0, r_qn};
    assign pv_sat = pv_sum[skf_pkg::VAR_W] ? '1 : pv_sum[skf_pkg::VAR_W-1:0];
    assign den    = {1'b0, r_pv} + {1'b0, r_rn};

    always_comb begin
        pred_ctrl.load = in_fire;
        pred_ctrl.step = (r_state == S_PRED);
        pred_ctrl.last = (r_cnt == PRED_LAST);
        corr_ctrl.load = (r_state == S_SUM);
        corr_ctrl.step = (r_state == S_CORR);
        corr_ctrl.last = (r_cnt == CORR_LAST);
    end

    skf_ser_mul #(
        .MW     (skf_pkg::DATA_W),
        .LW     (skf_pkg::DATA_W),
        .SIGNED (1'b1)
    ) u_mul_ax (
        .i_clk    (i_clk),
        .i_ctrl   (pred_ctrl),
        .i_mcand  (r_a),
        .i_mplier (r_est),
        .o_prod   (prod_ax)
    );

    skf_ser_mul #(
        .MW     (skf_pkg::DATA_W),
        .LW     (skf_pkg::DATA_W),
        .SIGNED (1'b1)
    ) u_mul_bu (
        .i_clk    (i_clk),
        .i_ctrl   (pred_ctrl),
        .i_mcand  (r_b),
        .i_mplier (i_in_data.control_input),
        .o_prod   (prod_bu)
    );

    skf_div #(
        .QW (KW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_PREP),
        .i_num   (r_pv),
        .i_den   (den),
        .o_busy  (div_busy),
        .o_quot  (div_quot)
    );

    // exact sum of both products, floored and saturated
    always_comb begin
        pred_sum = {prod_ax[PW-1], prod_ax} + {prod_bu[PW-1], prod_bu};
        pred_sh  = pred_sum >>> FRAC_BITS;
        if ((&pred_sh[PW:skf_pkg::DATA_W-1]) || !(|pred_sh[PW:skf_pkg::DATA_W-1])) begin
            pred_sat = pred_sh[skf_pkg::DATA_W-1:0];
        end else if (pred_sh[PW]) begin
            pred_sat = {1'b1, {(skf_pkg::DATA_W-1){1'b0}}};
        end else begin
            pred_sat = {1'b0, {(skf_pkg::DATA_W-1){1'b1}}};
        end
    end

    // a zero denominator means zero gain
    assign kval  = r_den_zero ? '0 : div_quot;
    assign innov = {r_z[skf_pkg::DATA_W-1], r_z} - {r_pred[skf_pkg::DATA_W-1], r_pred};

    skf_ser_mul #(
        .MW     (skf_pkg::DATA_W + 1),
        .LW     (KW),
        .SIGNED (1'b0)
    ) u_mul_corr (
        .i_clk    (i_clk),
        .i_ctrl   (corr_ctrl),
        .i_mcand  (innov),
        .i_mplier (kval),
        .o_prod   (prod_c)
    );

    skf_ser_mul #(
        .MW     (skf_pkg::DATA_W),
        .LW     (KW),
        .SIGNED (1'b0)
    ) u_mul_var (
        .i_clk    (i_clk),
        .i_ctrl   (corr_ctrl),
        .i_mcand  ({1'b0, r_pv}),
        .i_mplier (ONE - kval),
        .o_prod   (prod_v)
    );

    always_comb begin
        corr    = prod_c[CPW-1:FRAC_BITS];
        est_sum = {{5{r_pred[skf_pkg::DATA_W-1]}}, r_pred} + {corr[skf_pkg::DATA_W+3], corr};
        if ((&est_sum[skf_pkg::DATA_W+4:skf_pkg::DATA_W-1])
                || !(|est_sum[skf_pkg::DATA_W+4:skf_pkg::DATA_W-1])) begin
            est_sat = est_sum[skf_pkg::DATA_W-1:0];
        end else if (est_sum[skf_pkg::DATA_W+4]) begin
            est_sat = {1'b1, {(skf_pkg::DATA_W-1){1'b0}}};
        end else begin
            est_sat = {1'b0, {(skf_pkg::DATA_W-1){1'b1}}};
        end
        newp = prod_v[FRAC_BITS+skf_pkg::VAR_W-1:FRAC_BITS];
    end

    // sequencer, filter state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_a     <= skf_pkg::DATA_W'(ONE);
            r_b     <= '0;
            r_qn    <= skf_pkg::PROC_NOISE_RST;
            r_rn    <= skf_pkg::VAR_W'(ONE);
            r_est   <= '0;
            r_var   <= skf_pkg::VAR_W'(ONE);
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    skf_pkg::REG_TRANSITION: r_a  <= i_cfg_data;
                    skf_pkg::REG_CONTROL:    r_b  <= i_cfg_data;
                    skf_pkg::REG_PROC_NOISE: r_qn <= i_cfg_data[skf_pkg::VAR_W-1:0];
                    skf_pkg::REG_MEAS_NOISE: r_rn <= i_cfg_data[skf_pkg::VAR_W-1:0];
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_cnt   <= '0;
                    r_state <= S_PRED;
                end
                S_PRED: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == PRED_LAST) begin
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    r_cnt   <= '0;
                    r_state <= S_CORR;
                end
                S_CORR: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CORR_LAST) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (done_fire) begin
                        r_est   <= est_sat;
                        r_var   <= newp;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // per-request working values
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_z  <= i_in_data.measured_value;
            r_pv <= pv_sat;
        end
        if (r_state == S_PREP) begin
            r_den_zero <= (den == '0);
        end
        if (r_state == S_SUM) begin
            r_pred <= pred_sat;
            r_k    <= kval;
        end
    end

    // output register: hold while stalled, drop valid once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done_fire) begin
            r_out.estimate <= est_sat;
            r_out.gain     <= skf_pkg::GAIN_W'(r_k);
            r_out.variance <= newp;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // the gain must be complete before the prediction is summed
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SUM) |-> !div_busy)
        else $error("gain divider still busy when the gain is taken");

    a_gain_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CORR) |-> (r_k <= ONE))
        else $error("gain above one");

    a_accept_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state == S_PREP))
        else $error("accepted request did not start the sequence");

    a_var_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done_fire |=> (r_var <= $past(r_pv)))
        else $error("updated variance exceeds predicted variance");

    a_result_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done_fire |=> (r_out_valid && (r_state == S_IDLE)))
        else $error("result not presented after the sequence ended");

endmodule

>>> tb/sv/tb_top.sv
// Self-checking testbench for the scalar Kalman filter: directed and random requests.
module tb_top;

    localparam int     FRAC      = 16;
    localparam int     LATENCY   = FRAC + 36;
    localparam int     LIMIT     = 1_000_000;
    localparam int     MAX_NOTES = 40;
    localparam longint WORD_MAX  = 64'sd2147483647;
    localparam longint WORD_MIN  = -64'sd2147483648;
    localparam longint VAR_MAX   = 64'sd2147483647;
    localparam longint UNITY     = 64'sd1 << FRAC;

    logic                          i_clk     = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          in_valid  = 1'b0;
    skf_pkg::t_in_item             in_data   = '0;
    logic                          out_stall = 1'b0;
    logic                          cfg_we    = 1'b0;
    logic [skf_pkg::IDX_W-1:0]     cfg_index = skf_pkg::REG_TRANSITION;
    logic [skf_pkg::DATA_W-1:0]    cfg_data  = '0;
    logic                          o_in_stall;
    logic                          o_out_valid;
    skf_pkg::t_out_item            o_out_data;

    // predictor copy of configuration and filter state
    logic signed [31:0]   coef_a  = 32'sh0001_0000;
    logic signed [31:0]   coef_b  = '0;
    logic [30:0]          noise_q = skf_pkg::PROC_NOISE_RST;
    logic [30:0]          noise_r = 31'h0001_0000;
    logic signed [31:0]   x_est   = '0;
    logic [30:0]          p_var   = 31'h0001_0000;

    skf_pkg::t_out_item   pending_updates[$];
    int                   tx_idle_pct = 0;
    int                   rx_idle_pct = 0;
    int                   n_errors    = 0;
    int                   n_sent      = 0;
    int                   n_checked   = 0;
    int                   n_loads     = 0;
    int                   cycles      = 0;

    scalar_kalman_filter #(.FRAC_BITS(FRAC)) uut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("tb_top: timeout after %0d cycles", cycles);
            $display("tb_top: done, errors");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end

    function automatic longint clamp_word(longint v);
        if (v > WORD_MAX)
            return WORD_MAX;
        if (v < WORD_MIN)
            return WORD_MIN;
        return v;
    endfunction

    // advance the filter state by one measurement and return the update it emits
    function automatic skf_pkg::t_out_item kalman_update(skf_pkg::t_in_item req);
        logic signed [65:0] ea, ex, eb, eu, lin;
        longint             pred, pv, denom, k, innov, corr, est, np;
        skf_pkg::t_out_item res;
        ea    = coef_a;
        ex    = x_est;
        eb    = coef_b;
        eu    = req.control_input;
        lin   = (ea * ex + eb * eu) >>> FRAC;
        pred  = clamp_word(longint'(lin));
        pv    = longint'(p_var) + longint'(noise_q);
        if (pv > VAR_MAX)
            pv = VAR_MAX;
        denom = pv + longint'(noise_r);
        k     = (denom != 0) ? (pv << FRAC) / denom : 0;
        if (k > UNITY)
            k = UNITY;
        innov = longint'(req.measured_value) - pred;
        corr  = (k * innov) >>> FRAC;
        est   = clamp_word(pred + corr);
        np    = ((UNITY - k) * pv) >>> FRAC;
        x_est = est[31:0];
        p_var = np[30:0];
        res.estimate = est[31:0];
        res.gain     = k[16:0];
        res.variance = np[30:0];
        return res;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        n_errors++;
        if (n_errors <= MAX_NOTES)
            $display("tb_top: cycle %0d: %s got %0d want %0d", cycles, what, got, want);
    endtask

    always @(posedge i_clk) begin
        skf_pkg::t_out_item want;
        if (rst_n && o_out_valid && !out_stall) begin
            n_checked++;
            if (pending_updates.size() == 0) begin
                report_mismatch("update with none pending",
                                longint'(o_out_data.estimate), 0);
            end else begin
                want = pending_updates.pop_front();
                if (o_out_data.estimate !== want.estimate)
                    report_mismatch("estimate", longint'(o_out_data.estimate),
                                    longint'(want.estimate));
                if (o_out_data.gain !== want.gain)
                    report_mismatch("gain", longint'(o_out_data.gain),
                                    longint'(want.gain));
                if (o_out_data.variance !== want.variance)
                    report_mismatch("variance", longint'(o_out_data.variance),
                                    longint'(want.variance));
            end
        end
    end

    // called at a rising edge; returns at the edge that accepts the request
    task automatic send(input logic [31:0] z, input logic [31:0] u);
        skf_pkg::t_in_item req;
        req.measured_value = z;
        req.control_input  = u;
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 70)) @(posedge i_clk);
            else
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do @(posedge i_clk); while (o_in_stall);
        pending_updates.push_back(kalman_update(req));
        n_sent++;
    endtask

    // hold off the sender until every pending update has arrived
    task automatic drain(input int settle);
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_updates.size() != 0)
            @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic load_config(input logic [31:0] a, input logic [31:0] b,
                               input logic [30:0] q, input logic [30:0] r);
        drain(LATENCY + 8);
        cfg_we    <= 1'b1;
        cfg_index <= skf_pkg::REG_TRANSITION;
        cfg_data  <= a;
        @(posedge i_clk);
        cfg_index <= skf_pkg::REG_CONTROL;
        cfg_data  <= b;
        @(posedge i_clk);
        // top bit of the noise registers is dropped by the block
        cfg_index <= skf_pkg::REG_PROC_NOISE;
        cfg_data  <= {1'($urandom), q};
        @(posedge i_clk);
        cfg_index <= skf_pkg::REG_MEAS_NOISE;
        cfg_data  <= {1'($urandom), r};
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        coef_a  = a;
        coef_b  = b;
        noise_q = q;
        noise_r = r;
        n_loads++;
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3, 4, 5: return 32'($urandom_range(0, 32'h000F_FFFF)) - 32'h0008_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_reset_defaults();
        send(32'h7FFF_FFFF, 32'h8000_0000);
        send(32'h8000_0000, 32'h7FFF_FFFF);
        send(32'h0000_0000, 32'h0000_0000);
        send(32'h0001_0000, 32'hFFFF_FFFF);
    endtask

    task automatic test_field_extremes();
        load_config(32'h0000_8000, 32'h0001_0000, 31'h0000_1000, 31'h0000_8000);
        send(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send(32'h8000_0000, 32'h8000_0000);
        send(32'hFFFF_FFFF, 32'h0000_0001);
        send(32'h0000_0001, 32'hFFFF_FFFF);
    endtask

    task automatic test_prediction_saturation();
        load_config(32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'd655, 31'h0001_0000);
        send(32'h8000_0000, 32'h7FFF_FFFF);
        send(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send(32'h7FFF_FFFF, 32'h8000_0000);
        load_config(32'h8000_0000, 32'h8000_0000, 31'd655, 31'h0001_0000);
        send(32'h8000_0000, 32'h8000_0000);
        send(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    endtask

    task automatic test_variance_saturation();
        load_config(32'h0001_0000, 32'h0000_0000, 31'h7FFF_FFFF, 31'h0000_0000);
        send(32'h1234_5678, 32'h0000_0000);
        load_config(32'h0001_0000, 32'h0000_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
        send(32'h8000_0000, 32'h0000_0000);
        send(32'h7FFF_FFFF, 32'h0000_0000);
    endtask

    task automatic test_zero_denominator();
        // the first request collapses the variance, later ones see P' + R = 0
        load_config(32'h0001_8000, 32'h0000_4000, 31'h0000_0000, 31'h0000_0000);
        send(32'h0100_0000, 32'h0001_0000);
        send(32'h8000_0000, 32'h0002_0000);
        send(32'h7FFF_FFFF, 32'hFFFE_0000);
        load_config(32'h0001_0000, 32'h0000_0000, 31'h0000_0000, 31'h7FFF_FFFF);
        send(32'h7FFF_FFFF, 32'h0000_0000);
    endtask

    task automatic test_random_traffic(input int tx_pct, input int rx_pct,
                                       input int n_sets, input int per_set);
        logic [31:0] a, b;
        logic [30:0] q, r;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        for (int s = 0; s < n_sets; s++) begin
            case ((n_loads + s) % 6)
                0: begin
                    a = 32'h0001_0000;
                    b = 32'($urandom_range(0, 32'h0002_0000)) - 32'h0001_0000;
                    q = 31'($urandom_range(0, 32'h0001_0000));
                    r = 31'($urandom_range(1, 32'h0010_0000));
                end
                1: begin
                    a = 32'($urandom_range(0, 32'h0003_0000)) - 32'h0001_8000;
                    b = $urandom;
                    q = 31'($urandom);
                    r = 31'($urandom);
                end
                2: begin
                    a = 32'h7FFF_FFFF;
                    b = 32'h8000_0000;
                    q = 31'h7FFF_FFFF;
                    r = 31'h0000_0000;
                end
                3: begin
                    a = 32'h8000_0000;
                    b = 32'h7FFF_FFFF;
                    q = 31'h0000_0000;
                    r = 31'h7FFF_FFFF;
                end
                4: begin
                    a = '0;
                    b = '0;
                    q = '0;
                    r = '0;
                end
                default: begin
                    a = $urandom;
                    b = $urandom;
                    q = 31'($urandom);
                    r = 31'($urandom);
                end
            endcase
            load_config(a, b, q, r);
            for (int i = 0; i < per_set; i++) begin
                if ($urandom_range(0, 99) == 0)
                    drain(0);
                send(pick_word(), pick_word());
            end
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);
        tx_idle_pct = 37;
        rx_idle_pct = 74;
        test_reset_defaults();
        test_field_extremes();
        test_prediction_saturation();
        test_variance_saturation();
        test_zero_denominator();
        test_random_traffic(37, 74, 4, 120);
        test_random_traffic(74, 37, 4, 120);
        test_random_traffic(0, 0, 4, 120);
        drain(LATENCY + 8);
        $display("tb_top: %0d requests, %0d updates checked, %0d register loads, %0d mismatches",
                 n_sent, n_checked, n_loads, n_errors);
        $display("tb_top: reset values, field extremes, saturation, zero gain, three stall mixes");
        if (n_errors == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
